### rtl/dfr_pkg.sv
`default_nettype none

package dfr_pkg;

  localparam logic [7:0]  CH_DLE   = 8'h10;
  localparam logic [7:0]  CH_STX   = 8'h02;
  localparam logic [7:0]  CH_ETX   = 8'h03;
  localparam logic [7:0]  CH_EOT   = 8'h04;
  localparam logic [7:0]  CH_ZERO  = 8'h00;
  localparam logic [7:0]  CH_ONES  = 8'hFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_NORMAL   = 3'd0,
    PH_DLE      = 3'd1,
    PH_CRC_HI   = 3'd2,
    PH_CRC_LO   = 3'd3,
    PH_CNT_ZERO = 3'd4,
    PH_CNT_ONES = 3'd5
  } ph_e;

  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_RESTART = 2'd1,
    OP_END     = 2'd2
  } cmd_op_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_GOOD    = 2'd2,
    KIND_BAD     = 2'd3
  } kind_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_e;

  // one command from the deframer to the executer
  typedef struct packed {
    cmd_op_e     op;
    logic [7:0]  value;
    logic [7:0]  count;
    logic [15:0] crc;
  } cmd_t;

  // crc-16/modbus (reflected 0xa001, init 0xffff), one byte, bit by bit
  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/dfr_front.sv
`default_nettype none

module dfr_front
  import dfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  output cmd_t            cmd_o,
  output logic            push_o
);

  ph_e        phase_q, phase_d;
  logic [7:0] hi_q, hi_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      hi_q    <= 8'h00;
    end else begin
      phase_q <= phase_d;
      hi_q    <= hi_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    hi_d        = hi_q;
    push_o      = 1'b0;
    cmd_o.op    = OP_DATA;
    cmd_o.value = byte_i;
    cmd_o.count = 8'd1;
    cmd_o.crc   = {hi_q, byte_i};
    if (accept_i) begin
      unique case (phase_q)
        PH_DLE: begin
          phase_d = PH_NORMAL;
          if (byte_i == CH_STX || byte_i == CH_EOT) begin
            push_o   = 1'b1;
            cmd_o.op = OP_RESTART;
          end else if (byte_i == CH_ETX) begin
            phase_d = PH_CRC_HI;
          end else begin
            push_o = 1'b1;
          end
        end
        PH_CRC_HI: begin
          hi_d    = byte_i;
          phase_d = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          phase_d  = PH_NORMAL;
          push_o   = 1'b1;
          cmd_o.op = OP_END;
        end
        PH_CNT_ZERO, PH_CNT_ONES: begin
          phase_d     = PH_NORMAL;
          cmd_o.value = (phase_q == PH_CNT_ZERO) ? CH_ZERO : CH_ONES;
          cmd_o.count = byte_i - 8'd1;
          // count of zero or one adds nothing
          push_o      = (byte_i > 8'd1);
        end
        default: begin
          if (byte_i == CH_DLE) begin
            phase_d = PH_DLE;
          end else begin
            push_o = 1'b1;
            if (byte_i == CH_ZERO) begin
              phase_d = PH_CNT_ZERO;
            end else if (byte_i == CH_ONES) begin
              phase_d = PH_CNT_ONES;
            end else begin
              phase_d = PH_NORMAL;
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/dfr_queue.sv
`default_nettype none

module dfr_queue
  import dfr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

### rtl/dfr_back.sv
`default_nettype none

module dfr_back
  import dfr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  cmd_t             q_cmd_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       out_data_o,
  output logic [7:0]       out_rep_o,
  output logic [9:0]       out_len_o,
  output logic [15:0]      out_crc_o
);

  localparam int LEN_W = $clog2(BUFFER_DEPTH);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(BUFFER_DEPTH - 1);

  bk_e              state_q, state_d;
  logic [15:0]      crc_q, crc_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       rem_q, rem_d;
  logic [7:0]       fill_q, fill_d;
  logic             ov_q, ov_d;
  kind_e            kind_q, kind_d;
  logic [7:0]       data_q, data_d;
  logic [7:0]       rep_q, rep_d;
  logic [9:0]       olen_q, olen_d;
  logic [15:0]      ocrc_q, ocrc_d;

  logic             take;
  logic [7:0]       take_byte;
  logic [15:0]      crc_next;
  logic [LEN_W+9:0] len_ext;

  assign crc_next = crc_byte(crc_q, take_byte);
  assign len_ext  = {10'd0, len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      crc_q   <= CRC_INIT;
      len_q   <= '0;
      rem_q   <= 8'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      crc_q   <= crc_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    kind_q <= kind_d;
    data_q <= data_d;
    rep_q  <= rep_d;
    olen_q <= olen_d;
    ocrc_q <= ocrc_d;
  end

  always_comb begin
    state_d   = state_q;
    crc_d     = crc_q;
    len_d     = len_q;
    rem_d     = rem_q;
    fill_d    = fill_q;
    ov_d      = ov_q && !out_ready_i;
    kind_d    = kind_q;
    data_d    = data_q;
    rep_d     = rep_q;
    olen_d    = olen_q;
    ocrc_d    = ocrc_q;
    take      = 1'b0;
    take_byte = fill_q;
    q_pop_o   = (state_q == BK_IDLE) && q_valid_i && (!ov_q || out_ready_i);

    unique case (state_q)
      BK_IDLE: begin
        if (q_pop_o) begin
          ov_d   = 1'b1;
          data_d = 8'd0;
          rep_d  = 8'd0;
          olen_d = 10'd0;
          ocrc_d = 16'd0;
          unique case (q_cmd_i.op)
            OP_DATA: begin
              kind_d    = KIND_DATA;
              data_d    = q_cmd_i.value;
              rep_d     = q_cmd_i.count;
              take      = 1'b1;
              take_byte = q_cmd_i.value;
              fill_d    = q_cmd_i.value;
              if (q_cmd_i.count > 8'd1) begin
                rem_d   = q_cmd_i.count - 8'd1;
                state_d = BK_RUN;
              end
            end
            OP_END: begin
              kind_d = (crc_q == q_cmd_i.crc) ? KIND_GOOD : KIND_BAD;
              olen_d = len_ext[9:0];
              ocrc_d = q_cmd_i.crc;
              crc_d  = CRC_INIT;
              len_d  = '0;
            end
            default: begin
              kind_d = KIND_RESTART;
              crc_d  = CRC_INIT;
              len_d  = '0;
            end
          endcase
        end
      end
      default: begin
        // one run copy per cycle
        take  = 1'b1;
        rem_d = rem_q - 8'd1;
        if (rem_q == 8'd1) begin
          state_d = BK_IDLE;
        end
      end
    endcase

    if (take) begin
      if (len_q == LEN_LAST) begin
        len_d = '0;
        crc_d = CRC_INIT;
      end else begin
        len_d = len_q + LEN_W'(1);
        crc_d = crc_next;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_kind_o  = kind_q;
  assign out_data_o  = data_q;
  assign out_rep_o   = rep_q;
  assign out_len_o   = olen_q;
  assign out_crc_o   = ocrc_q;

endmodule

`default_nettype wire

### rtl/dle_frame_rle_receiver.sv
// a byte that gives a word is written to a queue entry and then to the output register before it
//   shows on the master side, when the queue is empty and the back end is idle
// the slave side takes one line byte per cycle while the queue is not full; a run count byte of n
//   adds n-1 fill bytes to the crc unit, one crc byte update per cycle, up to 254 for the longest run
// the two-entry command queue stalls the slave side when it fills while the crc unit is busy with a run
//   or a word waits on the master side
// reset: asynchronous, active low; phase idle, length 0, crc 0xffff, queue and output empty
`default_nettype none

module dle_frame_rle_receiver
  import dfr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // rx_byte[7:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // data_byte[7:0], repeat_count[15:8],
                                             // record_length[25:16], received_crc[41:26]
  output logic [1:0]       m_axis_tuser_o    // kind[1:0]
);

  logic        accept;
  cmd_t        push_cmd, pop_cmd;
  logic        q_push, q_full, q_pop, q_valid;
  logic [7:0]  o_data, o_rep;
  logic [9:0]  o_len;
  logic [15:0] o_crc;

  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  dfr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .cmd_o    (push_cmd),
    .push_o   (q_push)
  );

  dfr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .cmd_o      (pop_cmd)
  );

  dfr_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (m_axis_tuser_o),
    .out_data_o  (o_data),
    .out_rep_o   (o_rep),
    .out_len_o   (o_len),
    .out_crc_o   (o_crc)
  );

  assign m_axis_tdata_o = {6'd0, o_crc, o_len, o_rep, o_data};

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("command pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && !q_valid))
    else $error("command popped from empty queue");

  a_data_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_DATA) |-> (o_rep != 8'd0 && o_len == 10'd0))
    else $error("data word with bad repeat count or length");

  a_restart_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_RESTART) |-> (m_axis_tdata_o == 48'd0))
    else $error("restart word carries payload");

endmodule

`default_nettype wire

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dfr_pkg::*;

  localparam int DEPTH          = 1024;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 260;
  localparam int RANDOM_BYTES   = 350;

  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_MOSTLY,
    RX_SPARSE
  } rx_mode_e;

  typedef struct {
    kind_e       kind;
    logic [7:0]  value;
    logic [7:0]  reps;
    logic [9:0]  len;
    logic [15:0] crc;
  } word_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;

  dle_frame_rle_receiver #(
    .BUFFER_DEPTH(DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  always #5 clk_i = ~clk_i;

  // decoder state as the block should hold it
  ph_e         line_phase  = PH_NORMAL;
  int          rec_length  = 0;
  logic [15:0] rec_crc     = CRC_INIT;
  logic [7:0]  crc_hi_byte = 8'h00;
  word_t       expected_words[$];

  int       line_bytes_sent = 0;
  int       burst_left      = 0;
  bit       steady_sender   = 1'b0;
  bit       hold_req        = 1'b0;
  int       hold_left       = 0;
  rx_mode_e rx_mode         = RX_STEADY;
  int       mode_left       = 0;
  int       words_checked   = 0;
  int       mismatches      = 0;
  int       idle_cycles     = 0;
  int       kind_seen[4]    = '{default: 0};
  word_t    want_word;

  function automatic logic [15:0] crc16_arc_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic start_new_record();
    rec_length = 0;
    rec_crc = CRC_INIT;
  endtask

  task automatic count_decoded(logic [7:0] b);
    rec_crc = crc16_arc_next(rec_crc, b);
    rec_length++;
    // length wrap drops everything so far, the wrapping byte included
    if (rec_length >= DEPTH) start_new_record();
  endtask

  task automatic expect_word(kind_e k, logic [7:0] v, logic [7:0] r, logic [9:0] l,
                             logic [15:0] c);
    word_t w;
    w.kind = k;
    w.value = v;
    w.reps = r;
    w.len = l;
    w.crc = c;
    expected_words.push_back(w);
  endtask

  task automatic decode_line_byte(logic [7:0] b);
    logic [15:0] frame_crc;
    logic [7:0]  fill;
    case (line_phase)
      PH_DLE: begin
        line_phase = PH_NORMAL;
        if (b == CH_STX || b == CH_EOT) begin
          start_new_record();
          expect_word(KIND_RESTART, 8'h00, 8'h00, 10'd0, 16'h0000);
        end else if (b == CH_ETX) begin
          line_phase = PH_CRC_HI;
        end else begin
          count_decoded(b);
          expect_word(KIND_DATA, b, 8'd1, 10'd0, 16'h0000);
        end
      end
      PH_CRC_HI: begin
        crc_hi_byte = b;
        line_phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        line_phase = PH_NORMAL;
        frame_crc = {crc_hi_byte, b};
        expect_word((rec_crc == frame_crc) ? KIND_GOOD : KIND_BAD, 8'h00, 8'h00,
                    rec_length[9:0], frame_crc);
        start_new_record();
      end
      PH_CNT_ZERO, PH_CNT_ONES: begin
        fill = (line_phase == PH_CNT_ZERO) ? CH_ZERO : CH_ONES;
        line_phase = PH_NORMAL;
        if (b > 8'd1) begin
          repeat (b - 8'd1) count_decoded(fill);
          expect_word(KIND_DATA, fill, b - 8'd1, 10'd0, 16'h0000);
        end
      end
      default: begin
        line_phase = PH_NORMAL;
        if (b == CH_DLE) begin
          line_phase = PH_DLE;
        end else begin
          if (b == CH_ZERO) line_phase = PH_CNT_ZERO;
          else if (b == CH_ONES) line_phase = PH_CNT_ONES;
          count_decoded(b);
          expect_word(KIND_DATA, b, 8'd1, 10'd0, 16'h0000);
        end
      end
    endcase
  endtask

  task automatic send_byte(logic [7:0] b);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0 && !steady_sender) begin
      gap = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk_i); while (!s_tready);
    decode_line_byte(b);
    line_bytes_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  // plain data byte, escaped where the raw value would mean something else
  task automatic send_literal(logic [7:0] b);
    if (b == CH_DLE || b == CH_ZERO || b == CH_ONES) send_byte(CH_DLE);
    send_byte(b);
  endtask

  task automatic send_run(logic [7:0] fill, logic [7:0] count);
    send_byte(fill);
    send_byte(count);
  endtask

  task automatic send_restart(bit eot);
    send_byte(CH_DLE);
    send_byte(eot ? CH_EOT : CH_STX);
  endtask

  task automatic send_record_end(bit good);
    logic [15:0] c;
    send_byte(CH_DLE);
    send_byte(CH_ETX);
    c = rec_crc;
    if (!good) c ^= 16'($urandom_range(1, 16'hFFFF));
    send_byte(c[15:8]);
    send_byte(c[7:0]);
  endtask

  task automatic drain_words();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_escapes();
    send_restart(1'b0);
    send_byte(8'h5A);
    send_literal(CH_DLE);
    send_literal(CH_ZERO);
    send_literal(CH_ONES);
    send_restart(1'b1);
    send_byte(8'hA5);
    send_record_end(1'b1);
    drain_words();
  endtask

  task automatic test_run_counts();
    send_run(CH_ZERO, 8'd0);
    send_run(CH_ONES, 8'd1);
    send_run(CH_ZERO, 8'd2);
    send_run(CH_ONES, 8'hFF);
    send_run(CH_ZERO, CH_DLE);
    // crc bytes that look like escapes
    send_byte(CH_DLE);
    send_byte(CH_ETX);
    send_byte(CH_DLE);
    send_byte(CH_DLE);
    drain_words();
  endtask

  task automatic test_length_wrap();
    // 5 x 201 + 30 decoded bytes: wraps inside the last run
    send_restart(1'b0);
    repeat (5) send_run(CH_ONES, 8'd201);
    send_run(CH_ZERO, 8'd30);
    send_record_end(1'b1);
    // 4 x 254 + 8 lands exactly on the wrap
    send_restart(1'b0);
    repeat (4) send_run(CH_ZERO, 8'd254);
    repeat (8) send_literal(8'($urandom));
    send_record_end(1'b1);
    drain_words();
  endtask

  task automatic test_output_hold();
    hold_req = 1'b1;
    steady_sender = 1'b1;
    send_restart(1'b0);
    repeat (3) send_run(CH_ONES, 8'd254);
    repeat (10) send_literal(8'($urandom));
    send_record_end(1'b1);
    steady_sender = 1'b0;
    burst_left = 0;
    drain_words();
  endtask

  task automatic test_random_traffic();
    int start_count;
    int n;
    int pick;
    logic [7:0] b;
    start_count = line_bytes_sent;
    while (line_bytes_sent - start_count < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // raw noise, may leave the decoder in any phase
        n = $urandom_range(1, 8);
        repeat (n) send_byte(8'($urandom));
      end else begin
        if (pick < 90) send_restart(1'($urandom_range(0, 1)));
        n = $urandom_range(0, 16);
        repeat (n) begin
          pick = $urandom_range(0, 99);
          if (pick < 50) begin
            send_literal(8'($urandom));
          end else if (pick < 65) begin
            b = 8'($urandom);
            if (b == CH_STX || b == CH_ETX || b == CH_EOT) b = CH_DLE;
            send_byte(CH_DLE);
            send_byte(b);
          end else if (pick < 95) begin
            send_run(pick[0] ? CH_ONES : CH_ZERO,
                     ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 12)));
          end else begin
            send_restart(1'($urandom_range(0, 1)));
          end
        end
        send_record_end($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 15) == 0) drain_words();
    end
  endtask

  // receiver stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      case (rx_mode)
        RX_STEADY: m_tready <= 1'b1;
        RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
        RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
        default:   m_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind %0d tdata %h",
                 $time, m_tuser, m_tdata);
        mismatches++;
      end else begin
        want_word = expected_words.pop_front();
        words_checked++;
        kind_seen[m_tuser]++;
        check_field("kind", 16'(want_word.kind), 16'(m_tuser));
        check_field("data_byte", 16'(want_word.value), 16'(m_tdata[7:0]));
        check_field("repeat_count", 16'(want_word.reps), 16'(m_tdata[15:8]));
        check_field("record_length", 16'(want_word.len), 16'(m_tdata[25:16]));
        check_field("received_crc", want_word.crc, m_tdata[41:26]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d words still due", $time,
                 idle_cycles, expected_words.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_escapes();
    test_run_counts();
    test_length_wrap();
    test_output_hold();
    test_random_traffic();
    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("%0d line bytes in, %0d words out: %0d data, %0d restarts, %0d good, %0d bad",
             line_bytes_sent, words_checked, kind_seen[KIND_DATA], kind_seen[KIND_RESTART],
             kind_seen[KIND_GOOD], kind_seen[KIND_BAD]);
    $display("escapes, run counts 0..255, two length wraps, a long output hold, random records");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d words never came", mismatches, expected_words.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dfr_pkg.sv
rtl/dfr_front.sv
rtl/dfr_queue.sv
rtl/dfr_back.sv
rtl/dle_frame_rle_receiver.sv
tb/tb.sv
